// File: rtl/core/variable_record_byte_stack_assert.svh
// Assertion macros shared by the checker of the record byte stack.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef VARIABLE_RECORD_BYTE_STACK_ASSERT_SVH
`define VARIABLE_RECORD_BYTE_STACK_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define VRBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under an active-low reset.
`define VRBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/vrbs_pkg.sv
// Shared types, sizes and codes of the variable record byte stack.
// Used by every module of the block; depends on nothing.
package vrbs_pkg;

    // Store geometry.
    localparam int CAPACITY   = 1024;
    localparam int MAX_RECORD = 64;
    localparam int HDR_BYTES  = 4;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int TOP_W      = $clog2(CAPACITY + 1);
    localparam int LEN_W      = 7;
    localparam int KIND_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int STAT_W     = 2;

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Item kinds as they arrive on the input channel.
    localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHECK = 3'd4;

    // Operations handed from the front to the back.
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_CHECK = 3'd4;
    localparam logic [2:0] OP_ABORT = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;

    // One queued command.
    typedef struct packed {
        logic [2:0]        op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    // len > MAX_RECORD, or len plus header bytes do not fit below top.
    function automatic logic no_room(input logic [LEN_W-1:0] len,
                                     input logic [TOP_W-1:0] top);
        logic [TOP_W:0] need;
        need = (TOP_W + 1)'(len) + (TOP_W + 1)'(HDR_BYTES);
        return (len > LEN_W'(MAX_RECORD)) || (need > (TOP_W + 1)'(top));
    endfunction

endpackage

// File: rtl/core/vrbs_front.sv
// Front of the record byte stack: accepts input beats and classifies them.
// Depends on vrbs_pkg; feeds the command queue.
module vrbs_front (
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vrbs_pkg::KIND_W-1:0]   i_kind,
    input  logic [vrbs_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [vrbs_pkg::LEN_W-1:0]    i_length,
    input  logic                          i_q_full,
    output logic                          o_q_wr,
    output vrbs_pkg::t_cmd                o_q_cmd
);

    // The input side waits only while the queue is full.
    assign o_stall = i_q_full;
    assign o_q_wr  = i_valid && !i_q_full;

    // Map the item kind onto a back-end operation; unknown kinds only abort.
    always_comb begin
        o_q_cmd.data = i_data_byte;
        o_q_cmd.len  = i_length;
        unique case (i_kind)
            vrbs_pkg::KIND_PUSH:  o_q_cmd.op = vrbs_pkg::OP_PUSH;
            vrbs_pkg::KIND_POP:   o_q_cmd.op = vrbs_pkg::OP_POP;
            vrbs_pkg::KIND_PEEK:  o_q_cmd.op = vrbs_pkg::OP_PEEK;
            vrbs_pkg::KIND_CLEAR: o_q_cmd.op = vrbs_pkg::OP_CLEAR;
            vrbs_pkg::KIND_CHECK: o_q_cmd.op = vrbs_pkg::OP_CHECK;
            default:              o_q_cmd.op = vrbs_pkg::OP_ABORT;
        endcase
    end

endmodule

// File: rtl/core/vrbs_cmd_fifo.sv
// Short command queue that decouples the front from the back.
// Depends on vrbs_pkg for the command type and the depth.
module vrbs_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  vrbs_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output vrbs_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    vrbs_pkg::t_cmd                  r_mem [vrbs_pkg::Q_DEPTH];
    logic [vrbs_pkg::QPTR_W-1:0]     r_wp;
    logic [vrbs_pkg::QPTR_W-1:0]     r_rp;
    logic [vrbs_pkg::QCNT_W-1:0]     r_count;
    logic [vrbs_pkg::QCNT_W-1:0]     n_count;
    logic                            w_do_pop;

    assign o_full   = (r_count == vrbs_pkg::QCNT_W'(vrbs_pkg::Q_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rp];
    assign w_do_pop = i_pop && o_valid;

    // Occupancy follows the write and read beats.
    always_comb begin
        n_count = r_count;
        if (i_wr && !w_do_pop) begin
            n_count = r_count + vrbs_pkg::QCNT_W'(1);
        end else if (!i_wr && w_do_pop) begin
            n_count = r_count - vrbs_pkg::QCNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wp <= r_wp + vrbs_pkg::QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rp <= r_rp + vrbs_pkg::QPTR_W'(1);
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: rtl/core/vrbs_back.sv
// Back of the record byte stack: byte store, stack pointer, push and pop sequencer.
// Depends on vrbs_pkg; takes commands from the queue and drives the result beats.
module vrbs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  vrbs_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vrbs_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last,
    output logic [vrbs_pkg::STAT_W-1:0]   o_status,
    output logic                          o_is_empty,
    output logic [vrbs_pkg::TOP_W-1:0]    o_free_bytes
);

    localparam int AW = vrbs_pkg::ADDR_W;
    localparam int TW = vrbs_pkg::TOP_W;
    localparam int LW = vrbs_pkg::LEN_W;
    localparam int BW = vrbs_pkg::BYTE_W;
    localparam logic [TW-1:0] CAP_TOP = TW'(vrbs_pkg::CAPACITY);
    localparam logic [TW-1:0] HDR_TOP = TW'(vrbs_pkg::HDR_BYTES);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HDR    = 3'd1;
    localparam logic [2:0] S_RHDR   = 3'd2;
    localparam logic [2:0] S_STREAM = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [BW-1:0] r_store [vrbs_pkg::CAPACITY];
    logic [BW-1:0] r_rd_data;

    logic [2:0]    r_state, n_state;
    logic [TW-1:0] r_top, n_top;
    logic [LW-1:0] r_beat, n_beat;
    logic [LW-1:0] r_plen, n_plen;
    logic          r_rej, n_rej;
    logic [1:0]    r_hcnt, n_hcnt;
    logic [TW-1:0] r_hbase, n_hbase;
    logic [TW-1:0] r_base, n_base;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_len, n_len;
    logic          r_pop, n_pop;

    logic                         r_ov;
    logic [BW-1:0]                r_ob;
    logic                         r_olast;
    logic [vrbs_pkg::STAT_W-1:0]  r_ostat;
    logic                         r_oempty;
    logic [TW-1:0]                r_ofree;

    logic                         w_slot_free;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [BW-1:0]                w_wdata;
    logic                         w_re;
    logic [AW-1:0]                w_raddr;
    logic                         w_load;
    logic [BW-1:0]                w_lbyte;
    logic                         w_llast;
    logic [vrbs_pkg::STAT_W-1:0]  w_lstat;
    logic [TW-1:0]                w_lfree;

    logic [LW-1:0]                w_eff_len;
    logic                         w_eff_rej;
    logic [LW-1:0]                w_beats;
    logic                         w_final;
    logic [TW-1:0]                w_rbase;
    logic [BW-1:0]                w_min;
    logic [LW-1:0]                w_cnt;
    logic [TW:0]                  w_new_top;
    logic                         w_last_byte;

    assign w_slot_free = !r_ov || !i_stall;

    // Push bookkeeping: the first beat latches the length and the verdict.
    assign w_eff_len = (r_beat == '0) ? i_cmd.len : r_plen;
    assign w_eff_rej = (r_beat == '0) ? vrbs_pkg::no_room(i_cmd.len, r_top) : r_rej;
    assign w_beats   = (w_eff_len == '0) ? LW'(1) : w_eff_len;
    assign w_final   = ((LW + 1)'(r_beat) + (LW + 1)'(1)) >= (LW + 1)'(w_beats);

    // Header read: only the low header byte can be nonzero for a stored record.
    assign w_rbase   = r_top + HDR_TOP;
    assign w_min     = (BW'(r_len) < r_rd_data) ? BW'(r_len) : r_rd_data;
    assign w_cnt     = (w_min > BW'(vrbs_pkg::MAX_RECORD)) ? LW'(vrbs_pkg::MAX_RECORD)
                                                            : w_min[LW-1:0];
    assign w_new_top = (TW + 1)'(w_rbase) + (TW + 1)'(r_rd_data);
    assign w_last_byte = ((r_idx + LW'(1)) == r_cnt);

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_beat    = r_beat;
        n_plen    = r_plen;
        n_rej     = r_rej;
        n_hcnt    = r_hcnt;
        n_hbase   = r_hbase;
        n_base    = r_base;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_pop     = r_pop;
        o_cmd_pop = 1'b0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_raddr   = '0;
        w_load    = 1'b0;
        w_lbyte   = '0;
        w_llast   = 1'b1;
        w_lstat   = vrbs_pkg::ST_OK;
        w_lfree   = r_top;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_slot_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == vrbs_pkg::OP_PUSH) begin
                        // Data byte goes below the current top.
                        n_plen = w_eff_len;
                        n_rej  = w_eff_rej;
                        n_beat = w_final ? '0 : r_beat + LW'(1);
                        if (!w_eff_rej && w_eff_len != '0) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_top - TW'(w_eff_len) + TW'(r_beat));
                            w_wdata = i_cmd.data;
                        end
                        if (w_final && !w_eff_rej) begin
                            n_hbase = r_top - TW'(w_eff_len) - HDR_TOP;
                            n_hcnt  = '0;
                            n_state = S_HDR;
                        end else begin
                            w_load  = 1'b1;
                            w_llast = w_final;
                            w_lstat = w_eff_rej ? vrbs_pkg::ST_NO_ROOM : vrbs_pkg::ST_OK;
                        end
                    end else begin
                        // Any other command drops a partial push.
                        n_beat = '0;
                        n_rej  = 1'b0;
                        case (i_cmd.op) inside
                            vrbs_pkg::OP_POP, vrbs_pkg::OP_PEEK: begin
                                if (r_top >= CAP_TOP) begin
                                    w_load  = 1'b1;
                                    w_lstat = vrbs_pkg::ST_EMPTY;
                                end else begin
                                    w_re    = 1'b1;
                                    w_raddr = AW'(r_top);
                                    n_len   = i_cmd.len;
                                    n_pop   = (i_cmd.op == vrbs_pkg::OP_POP);
                                    n_state = S_RHDR;
                                end
                            end
                            vrbs_pkg::OP_CLEAR: begin
                                n_top   = CAP_TOP;
                                w_load  = 1'b1;
                                w_lfree = CAP_TOP;
                            end
                            vrbs_pkg::OP_CHECK: begin
                                w_load  = 1'b1;
                                w_lstat = vrbs_pkg::no_room(i_cmd.len, r_top)
                                          ? vrbs_pkg::ST_NO_ROOM : vrbs_pkg::ST_OK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            S_HDR: begin
                // Little-endian length header, one byte a cycle.
                w_we    = 1'b1;
                w_waddr = AW'(r_hbase + TW'(r_hcnt));
                w_wdata = (r_hcnt == 2'd0) ? BW'(r_plen) : '0;
                n_hcnt  = r_hcnt + 2'd1;
                if (r_hcnt == 2'd3) begin
                    n_top   = r_hbase;
                    n_state = S_EMIT;
                end
            end

            S_RHDR: begin
                // Header byte is back; size the run and free the record on pop.
                n_base = w_rbase;
                n_cnt  = w_cnt;
                n_idx  = '0;
                if (r_pop) begin
                    n_top = (w_new_top > (TW + 1)'(CAP_TOP)) ? CAP_TOP : w_new_top[TW-1:0];
                end
                if (w_cnt == '0) begin
                    n_state = S_EMIT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_rbase);
                    n_state = S_STREAM;
                end
            end

            S_STREAM: begin
                // One record byte per beat; the read data holds while stalled.
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    w_lbyte = r_rd_data;
                    w_llast = w_last_byte;
                    if (w_last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = AW'(r_base + TW'(r_idx) + TW'(1));
                        n_idx   = r_idx + LW'(1);
                    end
                end
            end

            S_EMIT: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= CAP_TOP;
            r_beat  <= '0;
            r_plen  <= '0;
            r_rej   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_beat  <= n_beat;
            r_plen  <= n_plen;
            r_rej   <= n_rej;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_hcnt  <= n_hcnt;
        r_hbase <= n_hbase;
        r_base  <= n_base;
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_len   <= n_len;
        r_pop   <= n_pop;
        if (w_load) begin
            r_ob     <= w_lbyte;
            r_olast  <= w_llast;
            r_ostat  <= w_lstat;
            r_ofree  <= w_lfree;
            r_oempty <= (w_lfree >= CAP_TOP);
        end
    end

    // Byte store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_store[w_raddr];
        end
    end

    assign o_valid      = r_ov;
    assign o_out_byte   = r_ob;
    assign o_last       = r_olast;
    assign o_status     = r_ostat;
    assign o_is_empty   = r_oempty;
    assign o_free_bytes = r_ofree;

endmodule

// File: rtl/core/variable_record_byte_stack.sv
// Top level of the variable record byte stack.
// Depends on vrbs_pkg, vrbs_front, vrbs_cmd_fifo and vrbs_back.
//
// Usage: items arrive on the input channel (i_valid, o_stall) as i_kind, i_data_byte
// and i_length; result beats leave on the output channel (o_valid, i_stall).
// A push of n bytes is sent as max(n,1) beats and gives one result beat per beat.
// Pop and peek give one beat per returned byte with o_last on the final one, or a
// single beat when none is returned; clear and space check give a single beat and
// unknown kinds give none. An accepted item enters a two-entry command queue and
// waits there until the sequencer is idle and its result slot is free; each result
// beat is registered. The byte-wide store port paces the work: a push beat writes
// one data byte, and the final push beat then writes the four header bytes before
// its result beat; pop and peek first read the header, then stream one byte per
// cycle while the receiver does not stall, each through a registered store read.
// Reset returns the stack to empty with all bytes free and drops any partial push;
// the store contents are left as they are and are never read before written.
// When the receiver stalls, the result beat holds on the ports and the sequencer
// waits; the queue keeps taking items until it is full, then o_stall rises.
module variable_record_byte_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vrbs_pkg::KIND_W-1:0]   i_kind,
    input  logic [vrbs_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [vrbs_pkg::LEN_W-1:0]    i_length,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [vrbs_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last,
    output logic [vrbs_pkg::STAT_W-1:0]   o_status,
    output logic                          o_is_empty,
    output logic [vrbs_pkg::TOP_W-1:0]    o_free_bytes
);

    logic           w_q_full;
    logic           w_q_wr;
    vrbs_pkg::t_cmd w_q_in;
    logic           w_q_valid;
    vrbs_pkg::t_cmd w_q_out;
    logic           w_q_pop;

    // Classify incoming beats.
    vrbs_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_length    (i_length),
        .i_q_full    (w_q_full),
        .o_q_wr      (w_q_wr),
        .o_q_cmd     (w_q_in)
    );

    // Decoupling queue.
    vrbs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_cmd   (w_q_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_out),
        .i_pop   (w_q_pop)
    );

    // Store and sequencer.
    vrbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_out),
        .o_cmd_pop    (w_q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_is_empty   (o_is_empty),
        .o_free_bytes (o_free_bytes)
    );

endmodule

// File: rtl/core/vrbs_checker.sv
// Port-level checker of the variable record byte stack, bound to the top level.
// Depends on vrbs_pkg and the macros in variable_record_byte_stack_assert.svh.
`include "variable_record_byte_stack_assert.svh"

module vrbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [vrbs_pkg::KIND_W-1:0]   i_kind,
    input logic [vrbs_pkg::BYTE_W-1:0]   i_data_byte,
    input logic [vrbs_pkg::LEN_W-1:0]    i_length,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [vrbs_pkg::BYTE_W-1:0]   o_out_byte,
    input logic                          o_last,
    input logic [vrbs_pkg::STAT_W-1:0]   o_status,
    input logic                          o_is_empty,
    input logic [vrbs_pkg::TOP_W-1:0]    o_free_bytes
);

    // A stalled input beat stays on the ports.
    `VRBS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_kind) && $stable(i_data_byte) && $stable(i_length), "input beat changed while stalled")

    // A stalled result beat stays on the ports.
    `VRBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_last) && $stable(o_status) && $stable(o_free_bytes), "result beat changed while stalled")

    // The empty flag agrees with the free byte count.
    `VRBS_ASSERT_NOW(a_empty_free, i_clk, i_rst_n, o_valid, o_is_empty == (o_free_bytes == vrbs_pkg::TOP_W'(vrbs_pkg::CAPACITY)), "empty flag and free count disagree")

    // The free count never exceeds the store size.
    `VRBS_ASSERT_NOW(a_free_range, i_clk, i_rst_n, o_valid, o_free_bytes <= vrbs_pkg::TOP_W'(vrbs_pkg::CAPACITY), "free count beyond capacity")

    // An empty-stack report is a single closing beat with no data on an empty stack.
    `VRBS_ASSERT_NOW(a_empty_report, i_clk, i_rst_n, o_valid && (o_status == vrbs_pkg::ST_EMPTY), o_last && (o_out_byte == '0) && o_is_empty, "malformed empty report")

endmodule

bind variable_record_byte_stack vrbs_checker u_checker (.*);

// File: tb/variable_record_byte_stack_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the variable record byte stack: random and directed beats,
// predicted results and back-pressure on both channels. Needs vrbs_pkg and the RTL.
module variable_record_byte_stack_test;

    // Sizes and codes taken from the package.
    localparam int CAPACITY   = vrbs_pkg::CAPACITY;
    localparam int MAX_RECORD = vrbs_pkg::MAX_RECORD;
    localparam int HDR_BYTES  = vrbs_pkg::HDR_BYTES;
    localparam int TOP_W      = vrbs_pkg::TOP_W;
    localparam int LEN_W      = vrbs_pkg::LEN_W;
    localparam int KIND_W     = vrbs_pkg::KIND_W;
    localparam int BYTE_W     = vrbs_pkg::BYTE_W;
    localparam int STAT_W     = vrbs_pkg::STAT_W;
    localparam logic [KIND_W-1:0] KIND_PUSH  = vrbs_pkg::KIND_PUSH;
    localparam logic [KIND_W-1:0] KIND_POP   = vrbs_pkg::KIND_POP;
    localparam logic [KIND_W-1:0] KIND_PEEK  = vrbs_pkg::KIND_PEEK;
    localparam logic [KIND_W-1:0] KIND_CLEAR = vrbs_pkg::KIND_CLEAR;
    localparam logic [KIND_W-1:0] KIND_CHECK = vrbs_pkg::KIND_CHECK;
    localparam logic [STAT_W-1:0] ST_OK      = vrbs_pkg::ST_OK;
    localparam logic [STAT_W-1:0] ST_NO_ROOM = vrbs_pkg::ST_NO_ROOM;
    localparam logic [STAT_W-1:0] ST_EMPTY   = vrbs_pkg::ST_EMPTY;

    localparam int CLK_HALF    = 6;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    // Kinds the block ignores apart from dropping a partial push.
    localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 3'd7;

    // Entries of the command queue: input beats plus pacing marks for the driver.
    typedef enum logic [2:0] {
        TAG_BEAT,
        TAG_DRAIN,
        TAG_HOLD,
        TAG_CALM_ON,
        TAG_CALM_OFF
    } t_tag;

    typedef struct {
        t_tag              tag;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_cmd_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic [STAT_W-1:0] status;
        logic              is_empty;
        logic [TOP_W-1:0]  free_bytes;
    } t_result;

    // Block ports.
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [KIND_W-1:0] i_kind = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic [LEN_W-1:0]  i_length = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last;
    logic [STAT_W-1:0] o_status;
    logic              o_is_empty;
    logic [TOP_W-1:0]  o_free_bytes;

    // Pacing shared between driver and receiver.
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   due_count = 0;
    int   fail_count = 0;
    int   beats_queued = 0;

    t_cmd_item cmd_q[$];
    t_result   result_due_q[$];

    // Shadow copy of the stack.
    logic [BYTE_W-1:0] stk_mem [CAPACITY];
    int                stk_top = CAPACITY;
    int                push_idx = 0;
    int                push_len = 0;
    bit                push_bad = 1'b0;

    variable_record_byte_stack u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_length     (i_length),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_status     (o_status),
        .o_is_empty   (o_is_empty),
        .o_free_bytes (o_free_bytes)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // need bytes exceed MAX_RECORD, or need plus the header exceeds room free bytes.
    function automatic bit lacks_room(int need, int room);
        return (need > MAX_RECORD) || (need + HDR_BYTES > room);
    endfunction

    // Queue one result beat, tagged with the stack state after the step.
    function automatic void due_result(logic [BYTE_W-1:0] b, logic fin, logic [STAT_W-1:0] st);
        t_result r;
        r.out_byte   = b;
        r.last       = fin;
        r.status     = st;
        r.is_empty   = (stk_top >= CAPACITY);
        r.free_bytes = TOP_W'(stk_top);
        result_due_q.push_back(r);
    endfunction

    // Apply one accepted input beat to the shadow stack and queue what it returns.
    function automatic void stack_apply(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] dat,
                                        logic [LEN_W-1:0] len);
        int                beats;
        int                stored;
        int                cnt;
        int                base;
        int                hdr;
        bit                fin;
        logic [BYTE_W-1:0] read_back[$];
        if (kind == KIND_PUSH) begin
            // The first beat of a record fixes its length and whether it fits.
            if (push_idx == 0) begin
                push_len = int'(len);
                push_bad = lacks_room(push_len, stk_top);
            end
            beats = (push_len == 0) ? 1 : push_len;
            fin = (push_idx + 1 >= beats);
            if (!push_bad) begin
                if (push_len != 0)
                    stk_mem[stk_top - push_len + push_idx] = dat;
                if (fin) begin
                    hdr = stk_top - push_len - HDR_BYTES;
                    for (int i = 0; i < HDR_BYTES; i++)
                        stk_mem[hdr + i] = BYTE_W'(push_len >> (8 * i));
                    stk_top = hdr;
                end
            end
            due_result('0, fin, push_bad ? ST_NO_ROOM : ST_OK);
            push_idx = fin ? 0 : push_idx + 1;
            return;
        end

        // Anything else drops a partial push.
        push_idx = 0;
        push_bad = 1'b0;
        if (kind == KIND_POP || kind == KIND_PEEK) begin
            if (stk_top >= CAPACITY) begin
                due_result('0, 1'b1, ST_EMPTY);
                return;
            end
            stored = 0;
            for (int i = 0; i < HDR_BYTES; i++)
                stored |= int'(stk_mem[stk_top + i]) << (8 * i);
            cnt = (int'(len) < stored) ? int'(len) : stored;
            if (cnt > MAX_RECORD)
                cnt = MAX_RECORD;
            base = stk_top + HDR_BYTES;
            for (int i = 0; i < cnt; i++)
                read_back.push_back(stk_mem[base + i]);
            if (kind == KIND_POP)
                stk_top = (base + stored > CAPACITY) ? CAPACITY : base + stored;
            if (cnt == 0) begin
                due_result('0, 1'b1, ST_OK);
            end else begin
                for (int i = 0; i < cnt; i++)
                    due_result(read_back[i], (i == cnt - 1), ST_OK);
            end
        end else if (kind == KIND_CLEAR) begin
            stk_top = CAPACITY;
            due_result('0, 1'b1, ST_OK);
        end else if (kind == KIND_CHECK) begin
            due_result('0, 1'b1, lacks_room(int'(len), stk_top) ? ST_NO_ROOM : ST_OK);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Stimulus helpers.
    task automatic add_beat(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] n);
        t_cmd_item it;
        it.tag  = TAG_BEAT;
        it.kind = k;
        it.data = d;
        it.len  = n;
        cmd_q.push_back(it);
        beats_queued++;
    endtask

    task automatic add_mark(t_tag t);
        t_cmd_item it;
        it.tag  = t;
        it.kind = '0;
        it.data = '0;
        it.len  = '0;
        cmd_q.push_back(it);
    endtask

    // Offer sent beats of a push of n bytes; later beats carry a random length.
    task automatic add_record(int n, int sent);
        for (int i = 0; i < sent; i++)
            add_beat(KIND_PUSH, BYTE_W'($urandom_range(255)),
                     (i == 0) ? LEN_W'(n) : LEN_W'($urandom_range(127)));
    endtask

    // Mostly short records, now and then up to the largest.
    function automatic int pick_record_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(8);
        else if (roll < 90)
            return $urandom_range(24, 9);
        return $urandom_range(MAX_RECORD, 25);
    endfunction

    function automatic logic [LEN_W-1:0] pick_read_len();
        if ($urandom_range(99) < 30)
            return LEN_W'($urandom_range(127));
        return LEN_W'($urandom_range(16));
    endfunction

    // Driver: presents the next beat when the slot is free, holds it while stalled.
    always @(posedge i_clk) begin : driver_p
        t_cmd_item         nxt;
        logic              v_n;
        logic [KIND_W-1:0] k_n;
        logic [BYTE_W-1:0] d_n;
        logic [LEN_W-1:0]  l_n;
        logic              calm_n;
        logic              hold_n;
        bit                draining;
        v_n    = i_valid;
        k_n    = i_kind;
        d_n    = i_data_byte;
        l_n    = i_length;
        calm_n = calm;
        hold_n = hold_req;
        if (!i_rst_n) begin
            v_n      = 1'b0;
            draining = 1'b0;
        end else if (!i_valid || !o_stall) begin
            v_n = 1'b0;
            if (draining && due_count == 0)
                draining = 1'b0;
            if (!draining && !(!calm && $urandom_range(99) < IDLE_PCT)) begin
                // Pacing marks take effect as they reach the head of the queue.
                while (cmd_q.size() > 0 && cmd_q[0].tag != TAG_BEAT && !draining) begin
                    nxt = cmd_q.pop_front();
                    case (nxt.tag)
                        TAG_DRAIN:    draining = 1'b1;
                        TAG_HOLD:     hold_n = !hold_n;
                        TAG_CALM_ON:  calm_n = 1'b1;
                        TAG_CALM_OFF: calm_n = 1'b0;
                        default:      ;
                    endcase
                end
                if (!draining && cmd_q.size() > 0) begin
                    nxt = cmd_q.pop_front();
                    v_n = 1'b1;
                    k_n = nxt.kind;
                    d_n = nxt.data;
                    l_n = nxt.len;
                end
            end
        end
        i_valid     <= v_n;
        i_kind      <= k_n;
        i_data_byte <= d_n;
        i_length    <= l_n;
        calm        <= calm_n;
        hold_req    <= hold_n;
    end

    // Receiver: random stalls, plus a long hold-off each time the driver asks.
    always @(posedge i_clk) begin : receiver_p
        logic hold_seen;
        int   hold_left;
        if (!i_rst_n) begin
            hold_seen = 1'b0;
            hold_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Monitor: predicts on every accepted input beat, checks every accepted result beat.
    always @(posedge i_clk) begin : monitor_p
        t_result want;
        if (!i_rst_n) begin
            stk_top  = CAPACITY;
            push_idx = 0;
            push_len = 0;
            push_bad = 1'b0;
            result_due_q.delete();
            due_count <= 0;
        end else begin
            if (i_valid && !o_stall)
                stack_apply(i_kind, i_data_byte, i_length);
            if (o_valid && !i_stall) begin
                if (result_due_q.size() == 0) begin
                    $error("result beat with nothing due: out_byte %0d status %0d",
                           o_out_byte, o_status);
                    fail_count++;
                end else begin
                    want = result_due_q.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(o_out_byte));
                    check_field("last", 16'(want.last), 16'(o_last));
                    check_field("status", 16'(want.status), 16'(o_status));
                    check_field("is_empty", 16'(want.is_empty), 16'(o_is_empty));
                    check_field("free_bytes", 16'(want.free_bytes), 16'(o_free_bytes));
                end
            end
            due_count <= result_due_q.size();
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    always @(posedge i_clk) begin : watchdog_p
        int quiet;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet = 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("variable_record_byte_stack regression: fail");
            $finish;
        end else begin
            quiet++;
        end
    end

    initial begin : stimulus_p
        int  roll;
        int  n;
        bit  held;
        bit  calm_done;

        // Directed: empty stack, zero-length records and reads, fit checks, rejection,
        // abandoned pushes and the ignored kinds.
        add_beat(KIND_POP, 8'h00, 7'd10);
        add_beat(KIND_PEEK, 8'hFF, 7'd0);
        add_beat(KIND_PUSH, 8'hFF, 7'd0);
        add_beat(KIND_PEEK, 8'h00, 7'd3);
        add_beat(KIND_POP, 8'h00, 7'd127);
        add_beat(KIND_PUSH, 8'h00, 7'd3);
        add_beat(KIND_PUSH, 8'hFF, 7'd127);
        add_beat(KIND_PUSH, 8'hA5, 7'd0);
        add_beat(KIND_PEEK, 8'h00, 7'd0);
        add_beat(KIND_PEEK, 8'h5A, 7'd127);
        add_beat(KIND_POP, 8'h00, 7'd2);
        add_beat(KIND_CHECK, 8'h00, 7'd64);
        add_beat(KIND_CHECK, 8'h00, 7'd65);
        add_beat(KIND_CHECK, 8'hFF, 7'd127);
        add_beat(KIND_CHECK, 8'h00, 7'd0);
        add_beat(KIND_PUSH, 8'h3C, 7'd100);
        add_beat(KIND_UNDEF_LO, 8'hFF, 7'd127);
        add_beat(KIND_PUSH, 8'h11, 7'd5);
        add_beat(KIND_PUSH, 8'h22, 7'd64);
        add_beat(KIND_CLEAR, 8'h00, 7'd0);
        add_beat(KIND_UNDEF_HI, 8'h81, 7'd64);
        add_beat(KIND_PEEK, 8'h00, 7'd1);
        add_mark(TAG_DRAIN);

        // Mixed traffic, with one long receiver hold-off in the middle.
        held = 1'b0;
        while (beats_queued < 170) begin
            if (!held && beats_queued >= 110) begin
                add_mark(TAG_HOLD);
                held = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 35) begin
                n = pick_record_len();
                add_record(n, (n == 0) ? 1 : n);
            end else if (roll < 42) begin
                // Broken push: a few beats, then something else cuts it off.
                add_record($urandom_range(127), $urandom_range(3, 1));
                add_beat(($urandom_range(1) != 0) ? KIND_CHECK : KIND_UNDEF_LO,
                         BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            end else if (roll < 60) begin
                add_beat(KIND_POP, BYTE_W'($urandom_range(255)), pick_read_len());
            end else if (roll < 75) begin
                add_beat(KIND_PEEK, BYTE_W'($urandom_range(255)), pick_read_len());
            end else if (roll < 85) begin
                add_beat(KIND_CHECK, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            end else if (roll < 89) begin
                add_beat(KIND_CLEAR, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            end else if (roll < 94) begin
                add_beat(KIND_W'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO)),
                         BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            end else begin
                add_beat(KIND_PUSH, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            end
        end

        // Fill the store with short records, mixed with fit checks and peeks.
        add_mark(TAG_CALM_ON);
        calm_done = 1'b0;
        held = 1'b0;
        while (beats_queued < 430) begin
            if (!calm_done && beats_queued >= 260) begin
                add_mark(TAG_CALM_OFF);
                calm_done = 1'b1;
            end
            if (!held && beats_queued >= 330) begin
                add_mark(TAG_HOLD);
                held = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 75) begin
                add_record($urandom_range(1), 1);
            end else if (roll < 85) begin
                n = $urandom_range(8, 2);
                add_record(n, n);
            end else if (roll < 95) begin
                add_beat(KIND_CHECK, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            end else begin
                add_beat(KIND_PEEK, BYTE_W'($urandom_range(255)), pick_read_len());
            end
        end

        // Sender waits for every result, then reads the stack back down.
        add_mark(TAG_DRAIN);
        while (beats_queued < 448) begin
            roll = $urandom_range(99);
            if (roll < 60)
                add_beat(KIND_POP, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            else if (roll < 80)
                add_beat(KIND_PEEK, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
            else
                add_beat(KIND_CHECK, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
        end
        add_beat(KIND_CLEAR, 8'h00, 7'd0);
        add_beat(KIND_POP, 8'h00, 7'd64);

        // Reset, then run until everything sent has been answered.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(negedge i_clk);
        while (cmd_q.size() != 0 || i_valid || due_count != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (result_due_q.size() != 0) begin
            $error("%0d result beats never arrived", result_due_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("variable_record_byte_stack regression: pass");
        else
            $display("variable_record_byte_stack regression: fail");
        $finish;
    end

endmodule
